// ===== rtl/lru_keyed_cache_unit_macros.svh =====
// ----------------------------------------------------------------------------
// LRU keyed cache assertion macros
// Concurrent assertion helpers shared by the cache RTL; empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef LRU_KEYED_CACHE_UNIT_MACROS_SVH
`define LRU_KEYED_CACHE_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, sampled on clk, off while rst_n is low
`define LKC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lru cache: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low
`define LKC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lru cache: next-cycle check failed");

`else

`define LKC_ASSERT_IMP(lbl, ante, cons)
`define LKC_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== rtl/lkc_pkg.sv =====
// ----------------------------------------------------------------------------
// LRU keyed cache package
// Sizes, operation codes and shared types of the fully associative cache.
// ----------------------------------------------------------------------------
package lkc_pkg;

    // Number of cache slots
    localparam int MAX_ENTRIES = 16;
    // Slot index and recency rank width
    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    // Occupancy count width, able to hold MAX_ENTRIES itself
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    localparam int KEY_W  = 31;
    localparam int DATA_W = 64;
    localparam int CAP_W  = 5;
    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    // Width for comparing occupancy against the capacity register
    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    typedef enum logic
    {
        KIND_GET = 1'b0,
        KIND_PUT = 1'b1
    } kind_t;

    typedef logic [MAX_ENTRIES-1:0][KEY_W-1:0] key_vec_t;
    typedef logic [MAX_ENTRIES-1:0][IDX_W-1:0] age_vec_t;

    // Outcome of the parallel tag compare and slot search
    typedef struct packed
    {
        logic             hit;
        logic [IDX_W-1:0] hit_idx;
        logic             free_ok;
        logic [IDX_W-1:0] free_idx;
        logic             oldest_ok;
        logic [IDX_W-1:0] oldest_idx;
    } lookup_t;

endpackage

// ===== rtl/lkc_ifs.sv =====
// ----------------------------------------------------------------------------
// LRU keyed cache channels
// Valid/ready request and response channels of the cache.
// ----------------------------------------------------------------------------

// Request channel: one get or put per beat
interface lkc_req_if;
    logic                       valid;
    logic                       ready;
    lkc_pkg::kind_t             kind;
    logic [lkc_pkg::KEY_W-1:0]  lookup_key;
    logic [lkc_pkg::DATA_W-1:0] payload_in;

    modport source (output valid, kind, lookup_key, payload_in, input ready);
    modport sink   (input valid, kind, lookup_key, payload_in, output ready);
endinterface

// Response channel: one result per request
interface lkc_rsp_if;
    logic                       valid;
    logic                       ready;
    logic                       found;
    logic [lkc_pkg::DATA_W-1:0] payload_out;

    modport source (output valid, found, payload_out, input ready);
    modport sink   (input valid, found, payload_out, output ready);
endinterface

// ===== rtl/lkc_lookup.sv =====
// ----------------------------------------------------------------------------
// LRU keyed cache lookup
// Parallel tag compare, lowest free slot and least recent slot search.
// ----------------------------------------------------------------------------
module lkc_lookup
(
    input  logic [lkc_pkg::KEY_W-1:0]       key,
    input  logic [lkc_pkg::MAX_ENTRIES-1:0] valid,
    input  lkc_pkg::key_vec_t               keys,
    input  lkc_pkg::age_vec_t               ages,
    input  logic [lkc_pkg::CNT_W-1:0]       count,
    output lkc_pkg::lookup_t                res
);

    logic [lkc_pkg::IDX_W-1:0] last_age;

    // The least recent slot holds rank count-1, ranks being distinct
    assign last_age = lkc_pkg::IDX_W'(count - lkc_pkg::CNT_W'(1));

    always_comb
    begin
        res = '0;
        // Compare every valid tag; keys are unique among valid slots
        for (int i = 0; i < lkc_pkg::MAX_ENTRIES; i++)
        begin
            if (valid[i] && keys[i] == key)
            begin
                res.hit     = 1'b1;
                res.hit_idx = lkc_pkg::IDX_W'(i);
            end
            if (valid[i] && ages[i] == last_age && count != '0)
            begin
                res.oldest_ok  = 1'b1;
                res.oldest_idx = lkc_pkg::IDX_W'(i);
            end
        end
        // Pick the lowest free slot
        for (int i = lkc_pkg::MAX_ENTRIES - 1; i >= 0; i--)
        begin
            if (!valid[i])
            begin
                res.free_ok  = 1'b1;
                res.free_idx = lkc_pkg::IDX_W'(i);
            end
        end
    end

endmodule

// ===== rtl/lru_keyed_cache_unit.sv =====
// ----------------------------------------------------------------------------
// LRU keyed cache unit
// Fully associative key/payload cache with least recently used replacement.
// ----------------------------------------------------------------------------
//
//  Channel | Dir | Handshake     | Beat contents
//  --------+-----+---------------+------------------------------------
//  req     | in  | valid/ready   | kind, lookup_key, payload_in
//  rsp     | out | valid/ready   | found, payload_out
//  cfg     | in  | cfg_we        | cfg_wdata = capacity_in_use
//
//  One beat a cycle sustained while responses are taken; each request
//  waits in the input register, where the tag compare and recency update
//  run, then sits in the response register.
//  Reset clears all slots and sets the capacity to 16; no clearing pass.
//  A stalled response holds the pipeline; the input register still takes
//  a beat while it is empty.
//
`include "lru_keyed_cache_unit_macros.svh"

module lru_keyed_cache_unit
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [lkc_pkg::CAP_W-1:0] cfg_wdata,
    lkc_req_if.sink                   req,
    lkc_rsp_if.source                 rsp
);

    localparam int N = lkc_pkg::MAX_ENTRIES;

    // Capacity register
    logic [lkc_pkg::CAP_W-1:0]  cap_reg;

    // Input register
    logic                       in_valid_reg;
    lkc_pkg::kind_t             in_kind_reg;
    logic [lkc_pkg::KEY_W-1:0]  in_key_reg;
    logic [lkc_pkg::DATA_W-1:0] in_data_reg;

    // Response register
    logic                       out_valid_reg;
    logic                       out_found_reg;
    logic [lkc_pkg::DATA_W-1:0] out_data_reg;

    // Slot state
    logic [N-1:0]               valid_reg, valid_next;
    lkc_pkg::age_vec_t          age_reg, age_next;
    logic [lkc_pkg::CNT_W-1:0]  count_reg, count_next;
    lkc_pkg::key_vec_t          key_mem;
    logic [lkc_pkg::DATA_W-1:0] data_mem [N];

    logic                       process;
    lkc_pkg::lookup_t           lk;
    logic [lkc_pkg::CMP_W-1:0]  cap_eff;
    logic                       evict;
    logic                       is_put;
    logic [lkc_pkg::IDX_W-1:0]  ins_idx;
    logic                       key_we;
    logic                       data_we;
    logic [lkc_pkg::IDX_W-1:0]  wr_idx;

    assign process   = in_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !in_valid_reg || process;
    assign is_put    = (in_kind_reg == lkc_pkg::KIND_PUT);

    assign rsp.valid       = out_valid_reg;
    assign rsp.found       = out_found_reg;
    assign rsp.payload_out = out_data_reg;

    lkc_lookup u_lookup
    (
        .key   (in_key_reg),
        .valid (valid_reg),
        .keys  (key_mem),
        .ages  (age_reg),
        .count (count_reg),
        .res   (lk)
    );

    // Clamp capacity to 1 .. MAX_ENTRIES
    always_comb
    begin
        cap_eff = lkc_pkg::CMP_W'(cap_reg);
        if (cap_eff == '0)
        begin
            cap_eff = lkc_pkg::CMP_W'(1);
        end
        else if (cap_eff > lkc_pkg::CMP_W'(N))
        begin
            cap_eff = lkc_pkg::CMP_W'(N);
        end
    end

    assign evict   = (lkc_pkg::CMP_W'(count_reg) >= cap_eff) && lk.oldest_ok;
    assign ins_idx = evict ? lk.oldest_idx : lk.free_idx;

    // Work out the next valid bits, ranks and count
    always_comb
    begin
        valid_next = valid_reg;
        age_next   = age_reg;
        count_next = count_reg;
        key_we     = 1'b0;
        data_we    = 1'b0;
        wr_idx     = lk.hit_idx;
        if (process)
        begin
            if (lk.hit)
            begin
                // Promote the hit slot; age the ones younger than it
                for (int i = 0; i < N; i++)
                begin
                    if (valid_reg[i] && age_reg[i] < age_reg[lk.hit_idx])
                    begin
                        age_next[i] = age_reg[i] + lkc_pkg::IDX_W'(1);
                    end
                end
                age_next[lk.hit_idx] = '0;
                data_we = is_put;
            end
            else if (is_put && (evict || lk.free_ok))
            begin
                // Insert as newest; every other valid slot ages by one
                for (int i = 0; i < N; i++)
                begin
                    if (valid_reg[i])
                    begin
                        age_next[i] = age_reg[i] + lkc_pkg::IDX_W'(1);
                    end
                end
                age_next[ins_idx]   = '0;
                valid_next[ins_idx] = 1'b1;
                if (!evict)
                begin
                    count_next = count_reg + lkc_pkg::CNT_W'(1);
                end
                key_we  = 1'b1;
                data_we = 1'b1;
                wr_idx  = ins_idx;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= lkc_pkg::CAP_RESET;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            valid_reg     <= '0;
            age_reg       <= '0;
            count_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                cap_reg <= cfg_wdata;
            end
            if (req.ready)
            begin
                in_valid_reg <= req.valid;
            end
            if (process)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            valid_reg <= valid_next;
            age_reg   <= age_next;
            count_reg <= count_next;
        end
    end

    // Capture the request beat
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            in_kind_reg <= req.kind;
            in_key_reg  <= req.lookup_key;
            in_data_reg <= req.payload_in;
        end
    end

    // Load the response; payload only on a get hit
    always_ff @(posedge clk)
    begin
        if (process)
        begin
            out_found_reg <= lk.hit;
            out_data_reg  <= (lk.hit && !is_put) ? data_mem[lk.hit_idx] : '0;
        end
    end

    // Write tag and payload stores
    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            key_mem[wr_idx] <= in_key_reg;
        end
        if (data_we)
        begin
            data_mem[wr_idx] <= in_data_reg;
        end
    end

    // Checks
    `LKC_ASSERT_IMP(a_count_matches_valid, 1'b1, lkc_pkg::CNT_W'($countones(valid_reg)) == count_reg)
    `LKC_ASSERT_NEXT(a_process_gives_response, process, out_valid_reg)
    `LKC_ASSERT_NEXT(a_put_leaves_entry, process && is_put, count_reg != '0)

endmodule
